@@ rtl/pcrs_pkg.sv @@
`timescale 1ns / 1ps
package pcrs_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_MUL_NL,
    ST_MUL_FL,
    ST_CORDIC,
    ST_ANGLE,
    ST_DIV,
    ST_BIN,
    ST_SQRT,
    ST_MEM_RD,
    ST_MEM_WR,
    ST_RD_CALC,
    ST_RD_MEM,
    ST_RD_OUT
  } pcrs_state_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HEIGHT_LOW  = 3'd0,
    REG_HEIGHT_HIGH = 3'd1,
    REG_SWEEP_START = 3'd2,
    REG_SWEEP_END   = 3'd3,
    REG_ANGLE_STEP  = 3'd4,
    REG_NEAR_LIMIT  = 3'd5,
    REG_FAR_LIMIT   = 3'd6,
    REG_EMPTY_FILL  = 3'd7
  } pcrs_reg_t;

  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = 17;
  localparam int SQRT_STEPS   = 21;

  // atan(2^-i) in 2^-32 turn
  localparam logic [31:0] CORDIC_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

endpackage

@@ rtl/pcrs_in_if.sv @@
`timescale 1ns / 1ps
interface pcrs_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [19:0] x_mm;
  logic signed [19:0] y_mm;
  logic signed [19:0] z_mm;
  logic               point_finite;

  modport source (output valid, mode, x_mm, y_mm, z_mm, point_finite, input ready);
  modport sink (input valid, mode, x_mm, y_mm, z_mm, point_finite, output ready);
endinterface

@@ rtl/pcrs_out_if.sv @@
`timescale 1ns / 1ps
interface pcrs_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  beam_index;
  logic [19:0] range_mm;
  logic        bin_empty;
  logic        last_beam;

  modport source (output valid, beam_index, range_mm, bin_empty, last_beam, input ready);
  modport sink (input valid, beam_index, range_mm, bin_empty, last_beam, output ready);
endinterface

@@ rtl/point_cloud_to_range_scan_top.sv @@
`timescale 1ns / 1ps
// Accumulate item: 4 multiply steps, 24 CORDIC steps, 17 divide steps, 21 square
//   root steps, then a read-modify-write of the bin store.
// Readout item: 17 divide steps for the beam count, store read, output load;
//   in_ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) restores register defaults, zeroes the cursor and
//   then runs a clearing pass over all MAX_BEAMS entries of the bin store.
module point_cloud_to_range_scan_top #(
  parameter int MAX_BEAMS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  pcrs_in_if.sink     in_ch,
  pcrs_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pcrs_pkg::*;

  localparam int IW  = $clog2(MAX_BEAMS);
  localparam int NBW = $clog2(MAX_BEAMS + 1);

  // configuration registers
  logic signed [19:0] height_low_r, height_high_r;
  logic signed [16:0] sweep_start_r, sweep_end_r;
  logic [16:0]        angle_step_r;
  logic [19:0]        near_limit_r, far_limit_r, empty_fill_r;

  pcrs_state_t st_r, st_nxt;
  logic [IW-1:0] clr_r;
  logic [IW-1:0] cursor_r;

  // datapath registers
  logic               mode_r;
  logic signed [19:0] x_r, y_r;
  logic [40:0]        r2_r;
  logic signed [43:0] cx_r, cy_r;
  logic signed [35:0] cz_r;
  logic               zero_r;
  logic [4:0]         cnt_r;
  logic [16:0]        dvd_r, rem_r, q_r;
  logic               rev_r;
  logic [41:0]        sop_r;
  logic [22:0]        srem_r;
  logic [20:0]        root_r;
  logic [IW-1:0]      c_r;
  logic               last_r;

  // output registers
  logic        out_valid_r;
  logic [9:0]  beam_r;
  logic [19:0] range_r;
  logic        empty_r, lastb_r;

  // bin store: {valid, range}
  logic [20:0]   mem [MAX_BEAMS];
  logic [20:0]   mem_rdata_r;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [20:0]   mem_wdata;

  logic in_fire, cfg_wr, out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cfg_pready = 1'b1;
  assign in_ch.ready = (st_r == ST_IDLE);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.beam_index = beam_r;
  assign out_ch.range_mm   = range_r;
  assign out_ch.bin_empty  = empty_r;
  assign out_ch.last_beam  = lastb_r;

  // register read
  always_comb begin
    case (pcrs_reg_t'(cfg_paddr[4:2]))
      REG_HEIGHT_LOW:  cfg_prdata = {{12{height_low_r[19]}}, height_low_r};
      REG_HEIGHT_HIGH: cfg_prdata = {{12{height_high_r[19]}}, height_high_r};
      REG_SWEEP_START: cfg_prdata = {{15{sweep_start_r[16]}}, sweep_start_r};
      REG_SWEEP_END:   cfg_prdata = {{15{sweep_end_r[16]}}, sweep_end_r};
      REG_ANGLE_STEP:  cfg_prdata = {15'd0, angle_step_r};
      REG_NEAR_LIMIT:  cfg_prdata = {12'd0, near_limit_r};
      REG_FAR_LIMIT:   cfg_prdata = {12'd0, far_limit_r};
      REG_EMPTY_FILL:  cfg_prdata = {12'd0, empty_fill_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // shared multiplier
  logic signed [20:0] mul_a;
  logic signed [41:0] prod;
  always_comb begin
    case (st_r)
      ST_MUL_XX: mul_a = 21'(x_r);
      ST_MUL_YY: mul_a = 21'(y_r);
      ST_MUL_NL: mul_a = $signed({1'b0, near_limit_r});
      ST_MUL_FL: mul_a = $signed({1'b0, far_limit_r});
      default:   mul_a = 21'(x_r);
    endcase
    prod = mul_a * mul_a;
  end

  logic too_near, too_far;
  assign too_near = r2_r < prod[40:0];
  assign too_far  = r2_r > prod[40:0];

  // quadrant fold before CORDIC
  logic signed [20:0] ix, iy;
  logic signed [35:0] iz;
  always_comb begin
    ix = 21'(x_r);
    iy = 21'(y_r);
    iz = '0;
    if (x_r < 0) begin
      if (y_r >= 0) begin
        ix = 21'(y_r);
        iy = -21'(x_r);
        iz = 36'sd1073741824;
      end else begin
        ix = -21'(y_r);
        iy = 21'(x_r);
        iz = -36'sd1073741824;
      end
    end
  end

  // one CORDIC vectoring step
  logic signed [43:0] xs, ys;
  logic signed [35:0] tab;
  assign xs  = cx_r >>> cnt_r;
  assign ys  = cy_r >>> cnt_r;
  assign tab = $signed({4'd0, CORDIC_TAB[cnt_r]});

  // angle rounding, clamp and window
  logic signed [35:0] zr;
  logic signed [19:0] a20;
  logic signed [17:0] ang, diff;
  logic               ang_out;
  always_comb begin
    zr = cz_r + 36'sd32768;
    a20 = zr[35:16];
    if (zero_r) ang = '0;
    else if (a20 > 20'sd32768) ang = 18'sd32768;
    else if (a20 < -20'sd32768) ang = -18'sd32768;
    else ang = a20[17:0];
    ang_out = (ang < 18'(sweep_start_r)) || (ang > 18'(sweep_end_r));
    diff = ang - 18'(sweep_start_r);
  end

  // restoring divide step
  logic [16:0] step_eff;
  logic [17:0] drem_s, drem_d;
  logic        dge;
  logic signed [17:0] span;
  assign step_eff = (angle_step_r == '0) ? 17'd1 : angle_step_r;
  assign drem_s   = {rem_r, dvd_r[16]};
  assign dge      = drem_s >= {1'b0, step_eff};
  assign drem_d   = drem_s - {1'b0, step_eff};
  assign span     = 18'(sweep_end_r) - 18'(sweep_start_r);

  // square root step
  logic [24:0] srem_s, strial, srem_d;
  logic        sge;
  assign srem_s = {srem_r, sop_r[41:40]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sge    = srem_s >= strial;
  assign srem_d = srem_s - strial;

  // beam count and cursor resolve
  logic [17:0]    qp1;
  logic [NBW-1:0] nb, c_ext;
  logic [IW-1:0]  c_sel;
  always_comb begin
    qp1 = {1'b0, q_r} + 18'd1;
    if (rev_r) nb = NBW'(1);
    else if (qp1 > 18'(MAX_BEAMS)) nb = NBW'(MAX_BEAMS);
    else nb = NBW'(qp1);
    c_sel = (NBW'(cursor_r) >= nb) ? '0 : cursor_r;
    c_ext = NBW'(c_sel);
  end

  logic [19:0] new_r;
  logic        upd;
  assign new_r = root_r[19:0];
  assign upd   = !mem_rdata_r[20] || (new_r < mem_rdata_r[19:0]);

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:   if (clr_r == IW'(MAX_BEAMS - 1)) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode) st_nxt = ST_DIV;
          else if (in_ch.point_finite && in_ch.z_mm >= height_low_r &&
                   in_ch.z_mm <= height_high_r) st_nxt = ST_MUL_XX;
        end
      end
      ST_MUL_XX:  st_nxt = ST_MUL_YY;
      ST_MUL_YY:  st_nxt = ST_MUL_NL;
      ST_MUL_NL:  st_nxt = too_near ? ST_IDLE : ST_MUL_FL;
      ST_MUL_FL: begin
        if (too_far) st_nxt = ST_IDLE;
        else if (x_r == '0 && y_r == '0) st_nxt = ST_ANGLE;
        else st_nxt = ST_CORDIC;
      end
      ST_CORDIC:  if (cnt_r == 5'(CORDIC_STEPS - 1)) st_nxt = ST_ANGLE;
      ST_ANGLE:   st_nxt = ang_out ? ST_IDLE : ST_DIV;
      ST_DIV:     if (cnt_r == 5'(DIV_STEPS - 1)) st_nxt = mode_r ? ST_RD_CALC : ST_BIN;
      ST_BIN:     st_nxt = (q_r < 17'(MAX_BEAMS)) ? ST_SQRT : ST_IDLE;
      ST_SQRT:    if (cnt_r == 5'(SQRT_STEPS - 1)) st_nxt = ST_MEM_RD;
      ST_MEM_RD:  st_nxt = ST_MEM_WR;
      ST_MEM_WR:  st_nxt = ST_IDLE;
      ST_RD_CALC: st_nxt = ST_RD_MEM;
      ST_RD_MEM:  st_nxt = ST_RD_OUT;
      ST_RD_OUT:  if (out_free) st_nxt = ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  // bin store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = c_r;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = c_r;
    case (st_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      ST_MEM_RD: begin
        mem_re    = 1'b1;
        mem_raddr = q_r[IW-1:0];
      end
      ST_MEM_WR: begin
        mem_we    = upd;
        mem_waddr = q_r[IW-1:0];
        mem_wdata = {1'b1, new_r};
      end
      ST_RD_MEM:  mem_re = 1'b1;
      ST_RD_OUT:  mem_we = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_CLEAR;
      clr_r         <= '0;
      cursor_r      <= '0;
      out_valid_r   <= 1'b0;
      height_low_r  <= 20'sd100;
      height_high_r <= 20'sd2000;
      sweep_start_r <= -17'sd32768;
      sweep_end_r   <= 17'sd32768;
      angle_step_r  <= 17'd182;
      near_limit_r  <= 20'd200;
      far_limit_r   <= 20'd30000;
      empty_fill_r  <= 20'd31000;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == ST_RD_OUT && out_free) begin
        out_valid_r <= 1'b1;
        cursor_r    <= last_r ? '0 : c_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (pcrs_reg_t'(cfg_paddr[4:2]))
          REG_HEIGHT_LOW:  height_low_r  <= cfg_pwdata[19:0];
          REG_HEIGHT_HIGH: height_high_r <= cfg_pwdata[19:0];
          REG_SWEEP_START: sweep_start_r <= cfg_pwdata[16:0];
          REG_SWEEP_END:   sweep_end_r   <= cfg_pwdata[16:0];
          REG_ANGLE_STEP:  angle_step_r  <= cfg_pwdata[16:0];
          REG_NEAR_LIMIT:  near_limit_r  <= cfg_pwdata[19:0];
          REG_FAR_LIMIT:   far_limit_r   <= cfg_pwdata[19:0];
          REG_EMPTY_FILL:  empty_fill_r  <= cfg_pwdata[19:0];
          default: ;
        endcase
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (st_r == ST_RD_OUT && out_free) begin
      beam_r  <= 10'(c_r);
      range_r <= mem_rdata_r[20] ? mem_rdata_r[19:0] : empty_fill_r;
      empty_r <= !mem_rdata_r[20];
      lastb_r <= last_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_r <= in_ch.mode;
          x_r    <= in_ch.x_mm;
          y_r    <= in_ch.y_mm;
          dvd_r  <= span[16:0];
          rev_r  <= span < 0;
          rem_r  <= '0;
          q_r    <= '0;
          cnt_r  <= '0;
        end
      end
      ST_MUL_XX: r2_r <= prod[40:0];
      ST_MUL_YY: r2_r <= r2_r + prod[40:0];
      ST_MUL_FL: begin
        cx_r   <= {{3{ix[20]}}, ix, 20'd0};
        cy_r   <= {{3{iy[20]}}, iy, 20'd0};
        cz_r   <= iz;
        zero_r <= (x_r == '0) && (y_r == '0);
        cnt_r  <= '0;
      end
      ST_CORDIC: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + tab;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - tab;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      ST_ANGLE: begin
        dvd_r <= diff[16:0];
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= dge ? drem_d[16:0] : drem_s[16:0];
        q_r   <= {q_r[15:0], dge};
        dvd_r <= {dvd_r[15:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_BIN: begin
        sop_r  <= {1'b0, r2_r};
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end
      ST_SQRT: begin
        srem_r <= sge ? srem_d[22:0] : srem_s[22:0];
        root_r <= {root_r[19:0], sge};
        sop_r  <= {sop_r[39:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
      end
      ST_RD_CALC: begin
        c_r    <= c_sel;
        last_r <= (c_ext == nb - 1'b1);
      end
      default: ;
    endcase
  end

endmodule

@@ sim/point_cloud_to_range_scan_top_test.sv @@
`timescale 1ns / 1ps
module point_cloud_to_range_scan_top_test;
  import pcrs_pkg::*;

  localparam int BEAMS_MAX  = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 100;

  typedef struct {
    bit [9:0]  beam;
    bit [19:0] rng;
    bit        empty;
    bit        last;
  } beam_read_t;

  // Shadow of the binning logic plus the queue of pending beam reads
  class scan_scoreboard;
    longint          h_low, h_high, sw_start, sw_end;
    longint unsigned a_step, near_lim, far_lim, fill;
    bit              hit [BEAMS_MAX];
    bit [19:0]       min_rng [BEAMS_MAX];
    int unsigned     cursor;
    beam_read_t      pending_reads[$];
    int              errors;

    function new();
      h_low = 100; h_high = 2000; sw_start = -32768; sw_end = 32768;
      a_step = 182; near_lim = 200; far_lim = 30000; fill = 31000;
      foreach (hit[i]) begin
        hit[i] = 0;
        min_rng[i] = '0;
      end
      cursor = 0;
      errors = 0;
    endfunction

    function void write_reg(pcrs_reg_t idx, logic [31:0] v);
      case (idx)
        REG_HEIGHT_LOW:  h_low = $signed(v[19:0]);
        REG_HEIGHT_HIGH: h_high = $signed(v[19:0]);
        REG_SWEEP_START: sw_start = $signed(v[16:0]);
        REG_SWEEP_END:   sw_end = $signed(v[16:0]);
        REG_ANGLE_STEP:  a_step = v[16:0];
        REG_NEAR_LIMIT:  near_lim = v[19:0];
        REG_FAR_LIMIT:   far_lim = v[19:0];
        REG_EMPTY_FILL:  fill = v[19:0];
        default: ;
      endcase
    endfunction

    function longint unsigned step_used();
      return (a_step == 0) ? 1 : a_step;
    endfunction

    function int unsigned beams();
      longint unsigned n;
      if (sw_end < sw_start) return 1;
      n = longint'(sw_end - sw_start) / step_used() + 1;
      if (n > BEAMS_MAX) n = BEAMS_MAX;
      return 32'(n);
    endfunction

    // atan2 in 1/65536 turn, CORDIC vectoring with floor shifts
    function longint heading(longint x, longint y);
      longint acc, t, xs, ys;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; acc = 64'sd16384 * 65536;
        end else begin
          x = -y; y = t; acc = -64'sd16384 * 65536;
        end
      end
      x = x * 1048576;
      y = y * 1048576;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; acc += longint'(CORDIC_TAB[i]);
        end else begin
          x -= ys; y += xs; acc -= longint'(CORDIC_TAB[i]);
        end
      end
      acc = (acc + 32768) >>> 16;
      if (acc > 32768) acc = 32768;
      if (acc < -32768) acc = -32768;
      return acc;
    endfunction

    function longint planar_root(longint v);
      longint r, t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
        t = r | (64'sd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_input(bit mode, logic signed [19:0] x, logic signed [19:0] y,
                             logic signed [19:0] z, bit fin);
      int unsigned nb, c;
      longint xl, yl, zl, r2, ang;
      longint unsigned bin;
      beam_read_t e;
      nb = beams();
      if (mode) begin
        c = (cursor >= nb) ? 0 : cursor;
        e.beam = c[9:0];
        e.rng = hit[c] ? min_rng[c] : fill[19:0];
        e.empty = !hit[c];
        e.last = (c == nb - 1);
        pending_reads.push_back(e);
        hit[c] = 0;
        min_rng[c] = '0;
        cursor = e.last ? 0 : c + 1;
        return;
      end
      xl = x; yl = y; zl = z;
      if (!fin) return;
      if (zl < h_low || zl > h_high) return;
      r2 = xl * xl + yl * yl;
      if (r2 < longint'(near_lim * near_lim) || r2 > longint'(far_lim * far_lim)) return;
      ang = heading(xl, yl);
      if (ang < sw_start || ang > sw_end) return;
      bin = longint'(ang - sw_start) / step_used();
      if (bin >= nb || bin >= BEAMS_MAX) return;
      xl = planar_root(r2) & 64'hFFFFF;
      if (!hit[bin] || xl < min_rng[bin]) begin
        hit[bin] = 1;
        min_rng[bin] = xl[19:0];
      end
    endfunction

    function void check_result(bit [9:0] beam, bit [19:0] rng, bit empty, bit last);
      beam_read_t e;
      if (pending_reads.size() == 0) begin
        $error("unexpected beam transfer: beam_index %0d", beam);
        errors++;
        return;
      end
      e = pending_reads.pop_front();
      if (beam !== e.beam) begin
        $error("beam_index: expected %0d, got %0d", e.beam, beam); errors++;
      end
      if (rng !== e.rng) begin
        $error("range_mm: expected %0d, got %0d", e.rng, rng); errors++;
      end
      if (empty !== e.empty) begin
        $error("bin_empty: expected %0d, got %0d", e.empty, empty); errors++;
      end
      if (last !== e.last) begin
        $error("last_beam: expected %0d, got %0d", e.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  pcrs_in_if  in_ch ();
  pcrs_out_if out_ch ();

  point_cloud_to_range_scan_top #(.MAX_BEAMS(BEAMS_MAX)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  scan_scoreboard scan_sb = new();
  int burst_left = 0;
  int quiet_cycles = 0;
  bit cfg_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: stall style is picked at random among three, and picked anew over the run
  int stall_style = 0;
  int stall_ph = 0;
  always @(negedge clk) begin
    if (stall_ph == 0) stall_style = $urandom_range(0, 2);
    stall_ph = (stall_ph + 1) % 50;
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready)
      scan_sb.check_result(out_ch.beam_index, out_ch.range_mm, out_ch.bin_empty,
                           out_ch.last_beam);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) || cfg_done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("[point_cloud_to_range_scan_top] ERROR");
      $finish;
    end
  end

  task automatic send_item(bit mode, logic signed [19:0] x, logic signed [19:0] y,
                           logic signed [19:0] z, bit fin);
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.x_mm = x;
    in_ch.y_mm = y;
    in_ch.z_mm = z;
    in_ch.point_finite = fin;
    do @(posedge clk); while (!in_ch.ready);
    scan_sb.note_input(mode, x, y, z, fin);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic read_beams(int n);
    for (int i = 0; i < n; i++) send_item(1'b1, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Wait until the block has drained, then let any point in flight finish
  task automatic settle();
    in_ch.valid = 1'b0;
    while (scan_sb.pending_reads.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(pcrs_reg_t idx, logic [31:0] v);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_done = 1'b1;
    scan_sb.write_reg(idx, v);
    @(negedge clk);
    cfg_done = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic write_all(int hl, int hh, int ss, int se, int st, int nl, int fl, int ef);
    write_reg(REG_HEIGHT_LOW, hl);
    write_reg(REG_HEIGHT_HIGH, hh);
    write_reg(REG_SWEEP_START, ss);
    write_reg(REG_SWEEP_END, se);
    write_reg(REG_ANGLE_STEP, st);
    write_reg(REG_NEAR_LIMIT, nl);
    write_reg(REG_FAR_LIMIT, fl);
    write_reg(REG_EMPTY_FILL, ef);
  endtask

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Mostly in-window points with random content, some noise
  task automatic random_points(int n);
    int span, zl, zh;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        span = (scan_sb.far_lim > 500000) ? 500000 : int'(scan_sb.far_lim) + 10;
        zl = (scan_sb.h_low < -524288) ? -524288 : int'(scan_sb.h_low);
        zh = (scan_sb.h_high > 524287) ? 524287 : int'(scan_sb.h_high);
        if (zh < zl) zh = zl;
        send_item(1'b0, pick(-span, span), pick(-span, span), pick(zl - 2, zh + 2),
                  $urandom_range(0, 15) != 0);
      end else begin
        send_item(1'b0, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int ss, se, nb;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.x_mm = '0;
    in_ch.y_mm = '0;
    in_ch.z_mm = '0;
    in_ch.point_finite = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cfg_done = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    burst_left = $urandom_range(1, 20);

    // Directed points under reset settings
    send_item(0, 1000, 0, 500, 1);
    send_item(0, 1500, 0, 500, 1);      // same bin, longer: kept out
    send_item(0, 700, 0, 500, 1);       // same bin, shorter: replaces
    send_item(0, 0, 1000, 500, 1);
    send_item(0, -1000, 1000, 500, 1);  // negative x, y above axis
    send_item(0, -1000, -1000, 500, 1); // negative x, y below axis
    send_item(0, -1000, 0, 500, 1);     // half turn, last bin
    send_item(0, 1000, -1, 500, 1);
    send_item(0, 1000, 0, 500, 0);      // non-finite
    send_item(0, 1000, 0, 99, 1);       // below height window
    send_item(0, 1000, 0, 2001, 1);     // above height window
    send_item(0, 100, 100, 500, 1);     // too near
    send_item(0, 30000, 1, 500, 1);     // too far
    send_item(0, -524288, 524287, 1000, 1);
    send_item(0, 524287, -524288, -524288, 1);
    read_beams(scan_sb.beams());
    settle();

    // Widest windows, two beams, origin point accepted
    write_all(-524288, 524287, -32768, 32768, 65536, 0, 741455, 1048575);
    send_item(0, 0, 0, 0, 1);
    send_item(0, -524288, -524288, 524287, 1);
    send_item(0, 524287, 524287, -524288, 1);
    send_item(0, -524288, 0, 0, 1);
    send_item(0, 3, -4, 0, 1);
    read_beams(3);                       // leaves cursor mid-scan
    settle();

    // Zero step, then reversed window
    write_all(-100, 100, 0, 20, 0, 0, 5000, 0);
    random_points(40);
    read_beams(10);
    settle();
    write_all(0, 0, 100, -100, 5, 10, 20, 12345);
    random_points(20);
    read_beams(3);
    settle();

    // Reset-like settings, long scan
    write_all(100, 2000, -32768, 32768, 182, 200, 30000, 31000);
    random_points(150);
    read_beams(scan_sb.beams());
    settle();

    // Random settings, short scans
    for (int ph = 0; ph < 10; ph++) begin
      ss = pick(-32768, 0);
      se = ($urandom_range(0, 7) == 0) ? ss - pick(1, 500) : pick(ss, 32768);
      nb = pick(2, 40);
      write_all(pick(-600, 200), pick(300, 4000), ss, se,
                ((se > ss) ? (se - ss) / nb : 0) + pick(1, 5),
                pick(0, 800), pick(1000, 60000), $urandom_range(0, 1048575));
      random_points(30);
      read_beams(scan_sb.beams() + ((ph % 3 == 0) ? -1 : 0));
      settle();
    end

    if (scan_sb.errors == 0 && scan_sb.pending_reads.size() == 0)
      $display("[point_cloud_to_range_scan_top] OK");
    else
      $display("[point_cloud_to_range_scan_top] ERROR");
    $finish;
  end
endmodule

@@ files.f @@
rtl/pcrs_pkg.sv
rtl/pcrs_in_if.sv
rtl/pcrs_out_if.sv
rtl/point_cloud_to_range_scan_top.sv
sim/point_cloud_to_range_scan_top_test.sv
